>>> rtl/core/abtp_pkg.sv
// Shared types and constants for the array binary tree preorder block.
package abtp_pkg;

    localparam int NODE_W   = 6;
    localparam int CHILD_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic [CHILD_W-1:0] CHILD_NONE = 7'h7F;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_ROOT   = 2'd1,
        ST_MALFORMED = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SCAN,
        S_START,
        S_VISIT,
        S_CHILD,
        S_POP,
        S_LOADV,
        S_ERR_ROOT,
        S_ERR_MAL,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    scan_clr;
        logic    scan_inc;
        logic    root_set;
        logic    start;
        logic    visit;
        logic    child;
        logic    emit;
        logic    pop;
        logic    loadv;
        logic    err;
        status_t err_code;
        logic    clear;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic overflow;
        logic scan_end;
        logic scan_hit;
        logic visit_limit;
        logic child_fault;
        logic child_next;
        logic stack_empty;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/core/abtp_node_if.sv
// Node record channel: valid/ready handshake with one record per request.
interface abtp_node_if;
    import abtp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [NODE_W-1:0]         node_index;
    logic signed [CHILD_W-1:0] left_child;
    logic signed [CHILD_W-1:0] right_child;
    logic                      last_node;

    modport source (
        output valid,
        output node_index,
        output left_child,
        output right_child,
        output last_node,
        input  ready
    );

    modport sink (
        input  valid,
        input  node_index,
        input  left_child,
        input  right_child,
        input  last_node,
        output ready
    );
endinterface

>>> rtl/core/abtp_visit_if.sv
// Preorder result channel: valid/ready handshake with one visited node per request.
interface abtp_visit_if;
    import abtp_pkg::*;

    logic                valid;
    logic                ready;
    logic [NODE_W-1:0]   visited_node;
    logic [STATUS_W-1:0] status;
    logic                last_result;

    modport source (
        output valid,
        output visited_node,
        output status,
        output last_result,
        input  ready
    );

    modport sink (
        input  valid,
        input  visited_node,
        input  status,
        input  last_result,
        output ready
    );
endinterface

>>> rtl/core/abtp_ctrl.sv
// Sequencer for record loading, root scan and the two-pass preorder walk.
module abtp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_last,
    output logic            in_ready,
    input  abtp_pkg::stat_t stat,
    output abtp_pkg::cmd_t  cmd
);
    import abtp_pkg::*;

    state_t state_reg, state_next;
    logic   pass2_reg, pass2_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        pass2_next = pass2_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.overflow)
                begin
                    state_next = S_ERR_MAL;
                end
                else if (stat.scan_end)
                begin
                    state_next = S_ERR_ROOT;
                end
                else if (stat.scan_hit)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = S_VISIT;
            end
            S_VISIT:
            begin
                if (stat.visit_limit)
                begin
                    state_next = S_ERR_MAL;
                end
                else
                begin
                    state_next = S_CHILD;
                end
            end
            S_CHILD:
            begin
                if (stat.child_fault)
                begin
                    state_next = S_ERR_MAL;
                end
                else if (!pass2_reg || stat.out_free)
                begin
                    if (stat.child_next)
                    begin
                        state_next = S_VISIT;
                    end
                    else if (!stat.stack_empty)
                    begin
                        state_next = S_POP;
                    end
                    else if (!pass2_reg)
                    begin
                        // check pass clean: replay the walk and emit it
                        state_next = S_START;
                        pass2_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_POP:
            begin
                state_next = S_LOADV;
            end
            S_LOADV:
            begin
                state_next = S_VISIT;
            end
            S_ERR_ROOT, S_ERR_MAL:
            begin
                if (stat.out_free)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_LOAD;
                pass2_next = 1'b0;
            end
            default:
            begin
                state_next = S_LOAD;
                pass2_next = 1'b0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        cmd.err_code = ST_OK;
        in_ready = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                in_ready     = 1'b1;
                cmd.load     = in_valid;
                cmd.scan_clr = in_valid && in_last;
            end
            S_SCAN:
            begin
                if (!stat.overflow && !stat.scan_end)
                begin
                    cmd.root_set = stat.scan_hit;
                    cmd.scan_inc = !stat.scan_hit;
                end
            end
            S_START:
            begin
                cmd.start = 1'b1;
            end
            S_VISIT:
            begin
                cmd.visit = !stat.visit_limit;
            end
            S_CHILD:
            begin
                if (!stat.child_fault && (!pass2_reg || stat.out_free))
                begin
                    cmd.child = 1'b1;
                    cmd.emit  = pass2_reg;
                end
            end
            S_POP:
            begin
                cmd.pop = 1'b1;
            end
            S_LOADV:
            begin
                cmd.loadv = 1'b1;
            end
            S_ERR_ROOT:
            begin
                cmd.err      = stat.out_free;
                cmd.err_code = ST_NO_ROOT;
            end
            S_ERR_MAL:
            begin
                cmd.err      = stat.out_free;
                cmd.err_code = ST_MALFORMED;
            end
            S_DONE:
            begin
                cmd.clear = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            pass2_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass2_reg <= pass2_next;
        end
    end

endmodule

>>> rtl/core/abtp_dpath.sv
// Child tables, parent marks, visit stack and result register.
module abtp_dpath #(
    parameter int MAX_NODES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  abtp_pkg::cmd_t                      cmd,
    output abtp_pkg::stat_t                     stat,
    input  logic [abtp_pkg::NODE_W-1:0]         node_index,
    input  logic signed [abtp_pkg::CHILD_W-1:0] left_child,
    input  logic signed [abtp_pkg::CHILD_W-1:0] right_child,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [abtp_pkg::NODE_W-1:0]         visited_node,
    output logic [abtp_pkg::STATUS_W-1:0]       status,
    output logic                                last_result
);
    import abtp_pkg::*;

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = $clog2(MAX_NODES + 1);

    localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_NODES);
    localparam logic [CNT_W-1:0]   CNT_MAX_1 = CNT_W'(MAX_NODES - 1);
    localparam logic [CHILD_W-1:0] CHILD_MAX = CHILD_W'(MAX_NODES);

    logic [CHILD_W-1:0] left_mem  [MAX_NODES];
    logic [CHILD_W-1:0] right_mem [MAX_NODES];
    logic [IDX_W-1:0]   stk_mem   [MAX_NODES];

    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [MAX_NODES-1:0] hp_reg, hp_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic [IDX_W-1:0]     root_reg, root_next;
    logic [IDX_W-1:0]     v_reg, v_next;
    logic [CNT_W-1:0]     sp_reg, sp_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic                 ov_reg, ov_next;

    logic [CHILD_W-1:0]   lrd_reg, rrd_reg;
    logic [IDX_W-1:0]     stk_rd_reg;
    logic [NODE_W-1:0]    out_node_reg;
    status_t              out_status_reg;
    logic                 out_last_reg;

    logic [CHILD_W-1:0]   lc_raw, rc_raw;
    logic                 ld_ok, lc_mark, rc_mark;
    logic [MAX_NODES-1:0] lmask, rmask;
    logic [CHILD_W-1:0]   count_ext;
    logic                 l_none, l_ok, l_bad, r_none, r_ok, r_bad;
    logic                 sp_full, sp_near;
    logic [CNT_W-1:0]     sp_dec;
    logic                 out_free;

    assign lc_raw = left_child;
    assign rc_raw = right_child;

    // load side
    assign ld_ok   = (count_reg < CNT_MAX) && (CHILD_W'(node_index) < CHILD_MAX);
    assign lc_mark = !lc_raw[CHILD_W-1] && (lc_raw < CHILD_MAX);
    assign rc_mark = !rc_raw[CHILD_W-1] && (rc_raw < CHILD_MAX);
    assign lmask   = lc_mark ? (MAX_NODES'(1) << lc_raw[IDX_W-1:0]) : '0;
    assign rmask   = rc_mark ? (MAX_NODES'(1) << rc_raw[IDX_W-1:0]) : '0;

    // child checks on the registered table read
    assign count_ext = CHILD_W'(count_reg);
    assign l_none    = (lrd_reg == CHILD_NONE);
    assign l_ok      = !lrd_reg[CHILD_W-1] && (lrd_reg < count_ext);
    assign l_bad     = !l_none && !l_ok;
    assign r_none    = (rrd_reg == CHILD_NONE);
    assign r_ok      = !rrd_reg[CHILD_W-1] && (rrd_reg < count_ext);
    assign r_bad     = !r_none && !r_ok;
    assign sp_full   = (sp_reg >= CNT_MAX);
    assign sp_near   = (sp_reg >= CNT_MAX_1);
    assign sp_dec    = sp_reg - 1'b1;
    assign out_free  = !ov_reg || out_ready;

    always_comb
    begin
        stat.overflow    = ovf_reg;
        stat.scan_end    = (scan_reg >= count_reg);
        stat.scan_hit    = !hp_reg[scan_reg[IDX_W-1:0]];
        stat.visit_limit = (n_reg >= count_reg);
        // right is pushed first, so the left push sees one more entry
        stat.child_fault = r_bad || l_bad || (r_ok && sp_full)
                           || (l_ok && (r_ok ? sp_near : sp_full));
        stat.child_next  = l_ok || r_ok;
        stat.stack_empty = (sp_reg == '0);
        stat.out_free    = out_free;
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        hp_next    = hp_reg;
        scan_next  = scan_reg;
        root_next  = root_reg;
        v_next     = v_reg;
        sp_next    = sp_reg;
        n_next     = n_reg;
        ov_next    = ov_reg;

        if (cmd.load)
        begin
            if (ld_ok)
            begin
                count_next = count_reg + 1'b1;
                hp_next    = hp_reg | lmask | rmask;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.scan_clr)
        begin
            scan_next = '0;
        end
        if (cmd.scan_inc)
        begin
            scan_next = scan_reg + 1'b1;
        end
        if (cmd.root_set)
        begin
            root_next = scan_reg[IDX_W-1:0];
        end
        if (cmd.start)
        begin
            v_next  = root_reg;
            sp_next = '0;
            n_next  = '0;
        end
        if (cmd.visit)
        begin
            n_next = n_reg + 1'b1;
        end
        if (cmd.child)
        begin
            // visit left next; right waits on the stack unless it is alone
            if (l_ok)
            begin
                v_next = lrd_reg[IDX_W-1:0];
            end
            else if (r_ok)
            begin
                v_next = rrd_reg[IDX_W-1:0];
            end
            if (l_ok && r_ok)
            begin
                sp_next = sp_reg + 1'b1;
            end
        end
        if (cmd.pop)
        begin
            sp_next = sp_dec;
        end
        if (cmd.loadv)
        begin
            v_next = stk_rd_reg;
        end
        if (cmd.clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
            hp_next    = '0;
        end

        if ((cmd.child && cmd.emit) || cmd.err)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            hp_reg    <= '0;
            scan_reg  <= '0;
            root_reg  <= '0;
            v_reg     <= '0;
            sp_reg    <= '0;
            n_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            hp_reg    <= hp_next;
            scan_reg  <= scan_next;
            root_reg  <= root_next;
            v_reg     <= v_next;
            sp_reg    <= sp_next;
            n_reg     <= n_next;
            ov_reg    <= ov_next;
        end
    end

    // child tables
    always_ff @(posedge clk)
    begin
        if (cmd.load && ld_ok)
        begin
            left_mem[node_index[IDX_W-1:0]]  <= lc_raw;
            right_mem[node_index[IDX_W-1:0]] <= rc_raw;
        end
        if (cmd.visit)
        begin
            lrd_reg <= left_mem[v_reg];
            rrd_reg <= right_mem[v_reg];
        end
    end

    // visit stack
    always_ff @(posedge clk)
    begin
        if (cmd.child && l_ok && r_ok)
        begin
            stk_mem[sp_reg[IDX_W-1:0]] <= rrd_reg[IDX_W-1:0];
        end
        if (cmd.pop)
        begin
            stk_rd_reg <= stk_mem[sp_dec[IDX_W-1:0]];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.err)
        begin
            out_node_reg   <= '0;
            out_status_reg <= cmd.err_code;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.child && cmd.emit)
        begin
            out_node_reg   <= NODE_W'(v_reg);
            out_status_reg <= ST_OK;
            out_last_reg   <= !l_ok && !r_ok && (sp_reg == '0);
        end
    end

    assign out_valid    = ov_reg;
    assign visited_node = out_node_reg;
    assign status       = out_status_reg;
    assign last_result  = out_last_reg;

endmodule

>>> rtl/core/array_binary_tree_preorder.sv
// Top level of the array binary tree preorder traversal block.
//
// Usage:
//   node_rec carries one node record per request (node_index, left_child,
//   right_child, last_node; a child of -1 means none). Records load at one
//   per cycle in S_LOAD. The request with last_node set closes the tree.
//   preorder then carries the visit order, one node per request, with
//   status and last_result; last_result marks the final request of a tree.
//   A no-root or malformed tree gives a single request with node 0.
// Sequence:
//   After the last record: a root scan from node 0 up to the root, then a
//   check walk and an emitting walk of the same shape. Each walk passes
//   through VISIT and CHILD for each node, plus POP and LOADV for each stack
//   pop (a node with no children and a nonempty stack), since the table and
//   stack memories are read through registers. The emitting walk waits in CHILD
//   until the previous result is taken; node_rec.ready is low until the tree is done.
// Reset and stall:
//   rst_n clears parent marks, record count and the result valid flag; the
//   child tables and stack need no clearing. A stalled preorder receiver
//   holds the walk in place; nothing is dropped or repeated.
module array_binary_tree_preorder #(
    parameter int MAX_NODES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    abtp_node_if.sink    node_rec,
    abtp_visit_if.source preorder
);
    import abtp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    abtp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (node_rec.valid),
        .in_last  (node_rec.last_node),
        .in_ready (node_rec.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    abtp_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .node_index   (node_rec.node_index),
        .left_child   (node_rec.left_child),
        .right_child  (node_rec.right_child),
        .out_ready    (preorder.ready),
        .out_valid    (preorder.valid),
        .visited_node (preorder.visited_node),
        .status       (preorder.status),
        .last_result  (preorder.last_result)
    );

endmodule

>>> tb/tb_abtp_checker.sv
// Request monitor, preorder predictor and result scoreboard for the tree traversal block.
`timescale 1ns / 100ps
module abtp_preorder_checker #(
    parameter int MAX_NODES = 64
) (
    input  logic  clk,
    input  logic  rst_n,
    abtp_node_if  node_rec,
    abtp_visit_if preorder,
    output int    fail_count,
    output int    pending
);
    import abtp_pkg::*;

    localparam int TBL_DEPTH = 1 << NODE_W;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        status_t           status;
        logic              last;
    } visit_t;

    // per-tree copy of the block state
    logic signed [CHILD_W-1:0] left_tbl  [TBL_DEPTH];
    logic signed [CHILD_W-1:0] right_tbl [TBL_DEPTH];
    bit                        parent_mark [TBL_DEPTH];
    int                        rec_count;
    bit                        overflowed;

    visit_t expected_visits[$];

    function automatic void clear_tree();
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            left_tbl[i]    = CHILD_NONE;
            right_tbl[i]   = CHILD_NONE;
            parent_mark[i] = 1'b0;
        end
        rec_count  = 0;
        overflowed = 1'b0;
    endfunction

    function automatic void store_record(logic [NODE_W-1:0] idx,
                                         logic signed [CHILD_W-1:0] lc,
                                         logic signed [CHILD_W-1:0] rc);
        if (rec_count >= MAX_NODES || int'(idx) >= MAX_NODES)
        begin
            overflowed = 1'b1;
        end
        else
        begin
            left_tbl[idx]  = lc;
            right_tbl[idx] = rc;
            if (lc >= 0)
                parent_mark[lc[NODE_W-1:0]] = 1'b1;
            if (rc >= 0)
                parent_mark[rc[NODE_W-1:0]] = 1'b1;
            rec_count++;
        end
    endfunction

    function automatic void push_error(status_t code);
        expected_visits.push_back('{node: '0, status: code, last: 1'b1});
    endfunction

    // Root scan, then an explicit-stack preorder walk; any fault replaces
    // the whole walk by one error result.
    function automatic void predict_preorder();
        visit_t            walk_q[$];
        logic [NODE_W-1:0] stk [TBL_DEPTH];
        logic [NODE_W-1:0] v;
        int                root;
        int                sp;
        int                kid;
        bit                fault;
        if (overflowed)
        begin
            push_error(ST_MALFORMED);
            return;
        end
        root = -1;
        for (int i = 0; i < rec_count; i++)
        begin
            if (!parent_mark[i])
            begin
                root = i;
                break;
            end
        end
        if (root < 0)
        begin
            push_error(ST_NO_ROOT);
            return;
        end
        stk[0] = root[NODE_W-1:0];
        sp     = 1;
        fault  = 1'b0;
        while (sp > 0 && !fault)
        begin
            sp--;
            v = stk[sp];
            if (walk_q.size() >= rec_count)
            begin
                fault = 1'b1;
            end
            else
            begin
                walk_q.push_back('{node: v, status: ST_OK, last: 1'b0});
                // right pushed first so left pops first
                for (int side = 0; side < 2 && !fault; side++)
                begin
                    kid = (side == 0) ? int'(right_tbl[v]) : int'(left_tbl[v]);
                    if (kid != -1)
                    begin
                        if (kid < 0 || kid >= rec_count || sp >= MAX_NODES)
                        begin
                            fault = 1'b1;
                        end
                        else
                        begin
                            stk[sp] = kid[NODE_W-1:0];
                            sp++;
                        end
                    end
                end
            end
        end
        if (fault)
        begin
            push_error(ST_MALFORMED);
        end
        else
        begin
            walk_q[walk_q.size()-1].last = 1'b1;
            foreach (walk_q[i])
                expected_visits.push_back(walk_q[i]);
        end
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        visit_t want;
        if (!rst_n)
        begin
            clear_tree();
            expected_visits.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (preorder.valid && preorder.ready)
            begin
                if (expected_visits.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, %s %0d %s %0d %s %0d",
                             $time, "actual node", preorder.visited_node,
                             "status", preorder.status,
                             "last", preorder.last_result);
                    fail_count++;
                end
                else
                begin
                    want = expected_visits.pop_front();
                    check_field("visited_node", want.node, preorder.visited_node);
                    check_field("status", want.status, preorder.status);
                    check_field("last_result", want.last, preorder.last_result);
                end
            end
            if (node_rec.valid && node_rec.ready)
            begin
                store_record(node_rec.node_index, node_rec.left_child, node_rec.right_child);
                if (node_rec.last_node)
                begin
                    predict_preorder();
                    clear_tree();
                end
            end
            pending <= expected_visits.size();
        end
    end

endmodule

>>> tb/tb_array_binary_tree_preorder.sv
// Top of the preorder traversal testbench: clock, reset, record stimulus and verdict.
`timescale 1ns / 100ps
module tb_array_binary_tree_preorder;
    import abtp_pkg::*;

    localparam int MAX_NODES    = 64;
    localparam int RANDOM_ITEMS = 66;
    // long receiver stall used to back the block up into its record input
    localparam int HOLD_CYCLES  = 400;
    // Slowest stretch without any request: root scan plus a 64-node check
    // walk plus the long receiver stall; take it many times over.
    localparam int WATCHDOG_LIMIT = 20000;
    // quiet time after the last expected result, to catch stray results
    localparam int DRAIN_CYCLES   = 200;

    typedef struct {
        logic [NODE_W-1:0]         idx;
        logic signed [CHILD_W-1:0] lc;
        logic signed [CHILD_W-1:0] rc;
    } tree_rec_t;

    logic clk;
    logic rst_n;

    abtp_node_if  node_rec ();
    abtp_visit_if preorder ();

    int fail_count;
    int pending;

    // idle rates in percent, changed per phase by the stimulus process
    int snd_idle_pct;
    int rcv_idle_pct;
    bit hold_req;
    int items_sent;

    tree_rec_t tree_q[$];

    array_binary_tree_preorder #(
        .MAX_NODES (MAX_NODES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .node_rec (node_rec),
        .preorder (preorder)
    );

    abtp_preorder_checker #(
        .MAX_NODES (MAX_NODES)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .node_rec   (node_rec),
        .preorder   (preorder),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: random back-pressure, plus one long hold on request.
    // The hold is counted here so the sender keeps offering records meanwhile.
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        preorder.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                preorder.ready <= 1'b0;
            end
            else
            begin
                preorder.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Ends the run if no request moves on either channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((node_rec.valid && node_rec.ready) || (preorder.valid && preorder.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic void add_rec(int idx, int lc, int rc);
        tree_rec_t r;
        r.idx = idx[NODE_W-1:0];
        r.lc  = lc[CHILD_W-1:0];
        r.rc  = rc[CHILD_W-1:0];
        tree_q.push_back(r);
    endfunction

    // Child value for corrupted or duplicate records. Nodes n..total-1 get no
    // record of their own, so they are never named here: either the child is
    // out of range (never followed), negative, none, or a real node. The
    // root is only named when no unrecorded node could take its place.
    function automatic int odd_child(int n, int total, int root, bit may_hit_root);
        int c;
        case ($urandom_range(3))
            0: c = -1;
            1:
            begin
                c = $urandom_range(n - 1);
                if (c == root && !may_hit_root)
                    c = -1;
            end
            2: c = (total <= 63) ? int'($urandom_range(63, total)) : -1;
            default: c = -int'($urandom_range(64, 2));
        endcase
        return c;
    endfunction

    // Random tree of n nodes numbered 0..n-1, records in random order.
    // extras: further records (repeats or high unused numbers) that raise the
    // count; faults: child fields overwritten with odd values.
    function automatic void build_tree(int n, int extras, int faults);
        int label [64];
        int lft [64];
        int rgt [64];
        int tmp;
        int j;
        int p;
        int side;
        int root;
        int total;
        int pos;
        int idx;
        tree_rec_t r;
        total = n + extras;
        for (int i = 0; i < 64; i++)
        begin
            label[i] = i;
            lft[i]   = -1;
            rgt[i]   = -1;
        end
        for (int i = n - 1; i > 0; i--)
        begin
            j        = $urandom_range(i);
            tmp      = label[i];
            label[i] = label[j];
            label[j] = tmp;
        end
        root = label[0];
        // attach each node to a free slot; favor the newest node for depth
        for (int k = 1; k < n; k++)
        begin
            do
            begin
                p    = $urandom_range(1) ? label[k-1] : label[$urandom_range(k - 1)];
                side = $urandom_range(1);
            end while (side ? (rgt[p] != -1) : (lft[p] != -1));
            if (side)
                rgt[p] = label[k];
            else
                lft[p] = label[k];
        end
        // reshuffle for the record order
        for (int i = n - 1; i > 0; i--)
        begin
            j        = $urandom_range(i);
            tmp      = label[i];
            label[i] = label[j];
            label[j] = tmp;
        end
        for (int i = 0; i < n; i++)
            add_rec(label[i], lft[label[i]], rgt[label[i]]);
        for (int e = 0; e < extras; e++)
        begin
            pos = $urandom_range(tree_q.size());
            if (total <= 63 && $urandom_range(1))
            begin
                idx = $urandom_range(63, total);
                r.idx = idx[NODE_W-1:0];
                r.lc  = odd_child(n, total, root, 1'b0);
                r.rc  = odd_child(n, total, root, 1'b0);
            end
            else
            begin
                // repeat of a node; later record overwrites, marks stay
                r = tree_q[$urandom_range(n - 1)];
                if ($urandom_range(1))
                begin
                    r.lc = odd_child(n, total, root, 1'b0);
                    r.rc = odd_child(n, total, root, 1'b0);
                end
            end
            tree_q.insert(pos, r);
        end
        for (int f = 0; f < faults; f++)
        begin
            pos = $urandom_range(tree_q.size() - 1);
            if ($urandom_range(1))
                tree_q[pos].lc = odd_child(n, total, root, extras == 0);
            else
                tree_q[pos].rc = odd_child(n, total, root, extras == 0);
        end
    endfunction

    // Sends the queued records as one tree; the final one carries last_node.
    // valid stays high between back-to-back requests.
    task automatic send_tree();
        for (int i = 0; i < tree_q.size(); i++)
        begin
            while ($urandom_range(99) < snd_idle_pct)
            begin
                node_rec.valid <= 1'b0;
                @(posedge clk);
            end
            node_rec.valid       <= 1'b1;
            node_rec.node_index  <= tree_q[i].idx;
            node_rec.left_child  <= tree_q[i].lc;
            node_rec.right_child <= tree_q[i].rc;
            node_rec.last_node   <= (i == tree_q.size() - 1);
            do @(posedge clk); while (!node_rec.ready);
            items_sent++;
        end
        tree_q.delete();
    endtask

    // Sender pause: nothing offered until every predicted result has come.
    // pending is a registered copy of the checker's queue size, hence the do-while.
    task automatic wait_for_results();
        node_rec.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_random_tree();
        int n;
        int extras;
        int faults;
        // mostly small trees, now and then a large one
        n      = ($urandom_range(11) == 0) ? int'($urandom_range(64, 13))
                                           : int'($urandom_range(12, 1));
        extras = ($urandom_range(3) == 0 && n < 62) ? int'($urandom_range(2, 1)) : 0;
        faults = ($urandom_range(9) < 3) ? int'($urandom_range(2, 1)) : 0;
        build_tree(n, extras, faults);
        send_tree();
    endtask

    initial
    begin : stimulus
        int phase_start;
        rst_n                <= 1'b0;
        node_rec.valid       <= 1'b0;
        node_rec.node_index  <= '0;
        node_rec.left_child  <= '0;
        node_rec.right_child <= '0;
        node_rec.last_node   <= 1'b0;
        hold_req     = 1'b0;
        items_sent   = 0;
        snd_idle_pct = 30;
        rcv_idle_pct = 47;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed trees ----
        // single node
        add_rec(0, -1, -1);
        send_tree();
        // self loop on node 0: every node has a parent, no root
        add_rec(0, 0, -1);
        send_tree();
        // root is node 2, children recorded after it
        add_rec(2, 0, 1);
        add_rec(0, -1, -1);
        add_rec(1, -1, -1);
        send_tree();
        // child beyond the loaded count
        add_rec(0, 5, -1);
        send_tree();
        // negative child other than none, on the left and on the right
        add_rec(0, -64, -1);
        send_tree();
        add_rec(1, -1, -2);
        add_rec(0, 1, -1);
        send_tree();
        // repeated node: second record drops the child, parent mark on 1 stays
        add_rec(0, 1, -1);
        add_rec(1, -1, -1);
        add_rec(0, -1, -1);
        send_tree();
        // loop back to node 1: more visits than records
        add_rec(0, 1, -1);
        add_rec(1, -1, 1);
        send_tree();
        // right-only chain
        add_rec(0, -1, 1);
        add_rec(1, -1, 2);
        add_rec(2, -1, -1);
        send_tree();
        // full size tree: the most results one tree can give
        build_tree(64, 0, 0);
        send_tree();
        // both children of each node point to the next one, and of the last node to itself: the stack fills
        for (int i = 0; i < 64; i++)
            add_rec(i, (i < 63) ? i + 1 : 63, (i < 63) ? i + 1 : 63);
        send_tree();
        // one record beyond the node limit
        build_tree(64, 0, 0);
        add_rec(63, -1, -1);
        send_tree();

        // ---- random trees in three idle phases ----
        for (int phase = 0; phase < 3; phase++)
        begin
            wait_for_results();
            case (phase)
                0:
                begin
                    snd_idle_pct = 30;
                    rcv_idle_pct = 47;
                end
                1:
                begin
                    snd_idle_pct = 47;
                    rcv_idle_pct = 30;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    // long receiver stall under a mid-size tree; the next
                    // trees keep the record input offered meanwhile
                    hold_req = 1'b1;
                    build_tree(24, 0, 0);
                    send_tree();
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < RANDOM_ITEMS / 3)
                send_random_tree();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/abtp_pkg.sv
rtl/core/abtp_node_if.sv
rtl/core/abtp_visit_if.sv
rtl/core/abtp_ctrl.sv
rtl/core/abtp_dpath.sv
rtl/core/array_binary_tree_preorder.sv
tb/tb_abtp_checker.sv
tb/tb_array_binary_tree_preorder.sv
